FILE: src/sit_pkg.sv
// ---------------------------------------------------------------------------
// sit_pkg: shared types and constants for the set intersection table
// Word formats, command codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package sit_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_HIT  = 1'b0,
        ST_FULL = 1'b1
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               status;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic start;   // capture word, begin scan at slot 0
        logic step;    // advance scan by one slot
        logic insert;  // write key into recorded free slot
        logic remove;  // clear valid bit of matching slot
        logic clear;   // drop all valid bits
        logic emit;    // load output register
        logic full;    // status of emitted word
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;      // registered compare matched at current slot
        logic last;     // compare of final slot is being presented
        logic has_free; // a free slot was seen
        logic is_full;  // count equals capacity
    } t_dp_stat;

endpackage

FILE: src/sit_ram.sv
// ---------------------------------------------------------------------------
// sit_ram: generic single-port write, single-port read RAM
// Registered read data, no reset on contents.
// ---------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/sit_datapath.sv
// ---------------------------------------------------------------------------
// sit_datapath: key store, valid bits, scan counter and output register
// Scans slots one per cycle through the key RAM with a registered compare.
// ---------------------------------------------------------------------------
module sit_datapath #(
    parameter int CAPACITY    = sit_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sit_pkg::t_in_word  i_word,
    input  sit_pkg::t_dp_cmd   i_cmd,
    output sit_pkg::t_dp_stat  o_stat,
    output sit_pkg::t_out_word o_word
);
    localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_WIDTH-1:0] r_key;
    logic [AW-1:0]          r_addr;   // slot presented to RAM
    logic [AW-1:0]          r_caddr;  // slot whose data is in rdata
    logic                   r_cvld;   // rdata is meaningful
    logic                   r_clast;
    logic [AW-1:0]          r_free;
    logic                   r_has_free;
    logic [CAPACITY-1:0]    r_valid;
    logic [CW-1:0]          r_count;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic                   w_hit;
    logic                   w_at_end;

    sit_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_keys (
        .i_clk  (i_clk),
        .i_we   (i_cmd.insert),
        .i_waddr(r_free),
        .i_wdata(r_key),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    assign w_at_end = ({{(32-AW){1'b0}}, r_addr} == 32'(CAPACITY - 1));
    assign w_hit    = r_cvld && r_valid[r_caddr] && (w_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_count    <= '0;
            r_cvld     <= 1'b0;
            r_has_free <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_key      <= VALUE_WIDTH'(i_word.value);
                r_addr     <= '0;
                r_cvld     <= 1'b0;
                r_has_free <= 1'b0;
            end else if (i_cmd.step) begin
                r_caddr <= r_addr;
                r_clast <= w_at_end;
                r_cvld  <= 1'b1;
                if (!w_at_end) r_addr <= r_addr + 1'b1;
                // track lowest free slot as scan goes
                if (!r_has_free && !r_valid[r_addr]) begin
                    r_free     <= r_addr;
                    r_has_free <= 1'b1;
                end
            end else begin
                r_cvld <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_count <= '0;
            end else if (i_cmd.insert) begin
                r_valid[r_free] <= 1'b1;
                r_count         <= r_count + 1'b1;
            end else if (i_cmd.remove) begin
                r_valid[r_caddr] <= 1'b0;
                r_count          <= r_count - 1'b1;
            end
        end
        if (i_cmd.emit) begin
            o_word.value_res <= 32'(r_key);
            o_word.status    <= i_cmd.full;
        end
    end

    assign o_stat.hit      = w_hit;
    assign o_stat.last     = r_cvld && r_clast;
    assign o_stat.has_free = r_has_free;
    assign o_stat.is_full  = (r_count == CW'(CAPACITY));

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !o_stat.is_full)
        else $error("insert into full table");
    a_remove_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.remove |-> r_valid[r_caddr])
        else $error("remove of empty slot");
endmodule

FILE: src/sit_ctrl.sv
// ---------------------------------------------------------------------------
// sit_ctrl: sequencer for load, probe and clear
// Runs one scan per load or probe word and issues insert, remove and emit commands.
// ---------------------------------------------------------------------------
module sit_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd_code,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  sit_pkg::t_dp_stat  i_stat,
    output sit_pkg::t_dp_cmd   o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DONE = 5'b00100,
        S_WAIT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    sit_pkg::t_cmd r_op;
    logic          r_out_valid;
    logic          r_full, n_full;
    logic          w_accept;
    logic          w_found;
    logic          w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_found    = i_stat.hit;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_full  = r_full;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (sit_pkg::t_cmd'(i_cmd_code))
                        sit_pkg::CMD_CLEAR: o_cmd.clear = 1'b1;
                        sit_pkg::CMD_NONE:  ;
                        default: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (w_found) begin
                    o_cmd.step = 1'b0;
                    n_state    = S_IDLE;
                    if (r_op == sit_pkg::CMD_PROBE) begin
                        o_cmd.remove = 1'b1;
                        // hold the word until the output register frees up
                        if (w_out_free) begin
                            o_cmd.emit = 1'b1;
                        end else begin
                            n_full  = 1'b0;
                            n_state = S_EMIT;
                        end
                    end
                end else if (i_stat.last) begin
                    o_cmd.step = 1'b0;
                    n_state    = (r_op == sit_pkg::CMD_LOAD) ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                // miss on load: insert, or drop when full
                if (i_stat.is_full || !i_stat.has_free) begin
                    if (w_out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.full = 1'b1;
                        n_state    = S_WAIT;
                    end else begin
                        n_full  = 1'b1;
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_WAIT;
                end
            end
            S_WAIT: n_state = S_IDLE;
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.full = r_full;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
            if (o_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
        if (w_accept) r_op <= sit_pkg::t_cmd'(i_cmd_code);
    end

    assign o_out_valid = r_out_valid;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output overwritten");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("output word dropped before taken");
endmodule

FILE: src/set_intersection_table.sv
// ---------------------------------------------------------------------------
// set_intersection_table: bounded set of distinct values for intersections
// Load inserts, probe reports and removes a hit, clear empties the set.
// ---------------------------------------------------------------------------
// channel   dir  handshake               payload
// in        in   i_in_valid/o_in_ready   t_in_word  {cmd, value}
// out       out  o_out_valid/i_out_ready t_out_word {value_res, status}
//
// Clear and unused commands need no scan. Load and probe scan the key RAM
// one slot a cycle and stop at a hit; a load miss then inserts the key or,
// when the set is full, emits it flagged full. A new word is taken only in
// idle, so the serial slot scan sets the rate.
// Reset empties the set at once through per-slot valid bits.
// A result not yet taken stalls the next emit, and with it the input side.
module set_intersection_table #(
    parameter int CAPACITY    = sit_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sit_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sit_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sit_pkg::t_out_word o_out_word
);
    sit_pkg::t_dp_cmd  w_cmd;
    sit_pkg::t_dp_stat w_stat;

    sit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd_code (i_in_word.cmd),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sit_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_word (i_in_word),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_word (o_out_word)
    );
endmodule

FILE: sim/tb_set_intersection_table.sv
// ---------------------------------------------------------------------------
// tb_set_intersection_table: self-checking bench for the set intersection table
// Streams load, probe, clear and unused words with random idling on both
// channels, predicts every result word from a local copy of the set and
// compares each output word in order against the predicted ones.
// ---------------------------------------------------------------------------
module tb_set_intersection_table;

    localparam int CAP      = sit_pkg::CAPACITY_DEF;
    localparam int SCAN_LAT = CAP + 20;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    sit_pkg::t_in_word  i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    sit_pkg::t_out_word o_out_word;

    // local copy of the set
    logic               set_valid [CAP];
    logic [31:0]        set_key   [CAP];
    int                 set_count;
    sit_pkg::t_out_word pending_q [$];

    int  n_errors    = 0;
    int  n_sent      = 0;
    int  n_hits      = 0;
    int  n_full      = 0;
    bit  quiet       = 1'b0;
    int  hold_cycles = 0;

    set_intersection_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #6000000;
        $display("tb_set_intersection_table failed");
        $finish;
    end

    // append one predicted word to the tail of the queue
    function automatic void queue_result(sit_pkg::t_out_word r);
        pending_q = {pending_q, r};
    endfunction

    function automatic void predict_word(sit_pkg::t_in_word w);
        logic [31:0]        k;
        int                 hit_slot;
        int                 free_idx;
        sit_pkg::t_out_word r;
        k = w.value;
        hit_slot = -1;
        free_idx = -1;
        for (int i = 0; i < CAP; i++) begin
            if (set_valid[i] && set_key[i] == k && hit_slot < 0) hit_slot = i;
            if (!set_valid[i] && free_idx < 0) free_idx = i;
        end
        case (sit_pkg::t_cmd'(w.cmd))
            sit_pkg::CMD_LOAD: begin
                if (hit_slot < 0) begin
                    if (set_count >= CAP || free_idx < 0) begin
                        r.value_res = k;
                        r.status = sit_pkg::ST_FULL;
                        queue_result(r);
                    end else begin
                        set_valid[free_idx] = 1'b1;
                        set_key[free_idx] = k;
                        set_count++;
                    end
                end
            end
            sit_pkg::CMD_PROBE: begin
                if (hit_slot >= 0) begin
                    set_valid[hit_slot] = 1'b0;
                    if (set_count > 0) set_count--;
                    r.value_res = k;
                    r.status = sit_pkg::ST_HIT;
                    queue_result(r);
                end
            end
            sit_pkg::CMD_CLEAR: begin
                for (int i = 0; i < CAP; i++) set_valid[i] = 1'b0;
                set_count = 0;
            end
            default: ;
        endcase
    endfunction

    // offer one word, hold it until taken, then maybe idle
    task automatic send_word(sit_pkg::t_cmd c, logic [31:0] v);
        sit_pkg::t_in_word w;
        int gap;
        w.cmd = c;
        w.value = v;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_word(w);
        n_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SCAN_LAT) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (!quiet && stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge i_clk) begin
        sit_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected output word value_res=%0h status=%0b",
                       o_out_word.value_res, o_out_word.status);
                n_errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_out_word.value_res !== e.value_res) begin
                    $error("value_res expected %0h actual %0h", e.value_res,
                           o_out_word.value_res);
                    n_errors++;
                end
                if (o_out_word.status !== e.status) begin
                    $error("status expected %0b actual %0b", e.status, o_out_word.status);
                    n_errors++;
                end
                if (e.status == sit_pkg::ST_FULL) n_full++; else n_hits++;
            end
        end
    end

    task automatic test_basic();
        send_word(sit_pkg::CMD_LOAD, 32'h8000_0000);
        send_word(sit_pkg::CMD_LOAD, 32'h7FFF_FFFF);
        send_word(sit_pkg::CMD_LOAD, 32'h0000_0000);
        send_word(sit_pkg::CMD_LOAD, 32'hFFFF_FFFF);
        send_word(sit_pkg::CMD_LOAD, 32'h7FFF_FFFF);   // duplicate
        send_word(sit_pkg::CMD_PROBE, 32'h1234_5678);  // miss
        send_word(sit_pkg::CMD_PROBE, 32'hFFFF_FFFF);
        send_word(sit_pkg::CMD_PROBE, 32'hFFFF_FFFF);  // already removed
        send_word(sit_pkg::CMD_NONE, 32'h8000_0000);   // ignored
        send_word(sit_pkg::CMD_PROBE, 32'h8000_0000);
        send_word(sit_pkg::CMD_LOAD, 32'h5555_5555);   // refills the lowest free slot
        send_word(sit_pkg::CMD_PROBE, 32'h0000_0000);
        send_word(sit_pkg::CMD_CLEAR, 32'hAAAA_AAAA);
        send_word(sit_pkg::CMD_PROBE, 32'h7FFF_FFFF);  // gone after clear
        send_word(sit_pkg::CMD_PROBE, 32'h5555_5555);
        wait_drained();
    endtask

    task automatic test_full();
        send_word(sit_pkg::CMD_CLEAR, '0);
        for (int i = 0; i < CAP; i++) send_word(sit_pkg::CMD_LOAD, 32'(i * 7 + 3));
        send_word(sit_pkg::CMD_LOAD, 32'hDEAD_BEEF);  // dropped, flagged
        send_word(sit_pkg::CMD_LOAD, 32'h0000_0003);  // duplicate while full
        send_word(sit_pkg::CMD_PROBE, 32'(CAP * 7 - 4));
        send_word(sit_pkg::CMD_LOAD, 32'hDEAD_BEEF);  // fits now
        send_word(sit_pkg::CMD_PROBE, 32'hDEAD_BEEF);
        wait_drained();
    endtask

    // long receiver hold-off while probes keep coming
    task automatic test_backpressure();
        send_word(sit_pkg::CMD_CLEAR, '0);
        for (int i = 0; i < 8; i++) send_word(sit_pkg::CMD_LOAD, 32'(i));
        hold_cycles = 3000;
        for (int i = 0; i < 8; i++) send_word(sit_pkg::CMD_PROBE, 32'(i));
        wait_drained();
    endtask

    task automatic run_random(int n_items);
        logic [31:0] pool [32];
        int done, size, nload, nprobe;
        done = 0;
        while (done < n_items) begin
            size = ($urandom_range(0, 19) == 0) ? 32 : $urandom_range(1, 12);
            for (int i = 0; i < size; i++)
                pool[i] = ($urandom_range(0, 9) == 0) ?
                          ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) : $urandom();
            if ($urandom_range(0, 9) != 0) begin
                send_word(sit_pkg::CMD_CLEAR, $urandom());
                done++;
            end
            nload = $urandom_range(1, size + 4);
            nprobe = $urandom_range(1, size + 4);
            for (int i = 0; i < nload; i++) begin
                if ($urandom_range(0, 24) == 0)
                    send_word(sit_pkg::t_cmd'($urandom_range(0, 3)), $urandom());
                else send_word(sit_pkg::CMD_LOAD, pool[$urandom_range(0, size - 1)]);
                done++;
            end
            for (int i = 0; i < nprobe; i++) begin
                if ($urandom_range(0, 9) == 0) send_word(sit_pkg::CMD_PROBE, $urandom());
                else if ($urandom_range(0, 24) == 0) send_word(sit_pkg::CMD_NONE, $urandom());
                else send_word(sit_pkg::CMD_PROBE, pool[$urandom_range(0, size - 1)]);
                done++;
            end
        end
    endtask

    initial begin
        int waited;
        for (int i = 0; i < CAP; i++) begin
            set_valid[i] = 1'b0;
            set_key[i] = '0;
        end
        set_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic();
        test_full();
        test_backpressure();
        run_random(1200);
        wait_drained();
        quiet = 1'b1;
        run_random(300);

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SCAN_LAT) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d predicted words never arrived", pending_q.size());
            n_errors++;
        end
        $display("covered %0d input words: %0d hit words, %0d full-set drops",
                 n_sent, n_hits, n_full);
        if (n_errors == 0) begin
            $display("tb_set_intersection_table passed");
        end else begin
            $display("tb_set_intersection_table failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/sit_pkg.sv
src/sit_ram.sv
src/sit_datapath.sv
src/sit_ctrl.sv
src/set_intersection_table.sv
sim/tb_set_intersection_table.sv
